// ----- hw/rtl/crcfrl_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrl_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// framed request link.
// ---------------------------------------------------------------------------
package crcfrl_pkg;

  // frame layout
  localparam int FRAME_LEN = 12;
  localparam int ADDR_W    = 4;

  localparam logic [3:0] POS_MAGIC   = 4'd0;
  localparam logic [3:0] POS_VERSION = 4'd1;
  localparam logic [3:0] POS_TYPE    = 4'd2;
  localparam logic [3:0] POS_SEQ     = 4'd3;
  localparam logic [3:0] POS_ARG_A   = 4'd4;
  localparam logic [3:0] POS_ARG_B   = 4'd5;
  localparam logic [3:0] POS_VAL_0   = 4'd6;
  localparam logic [3:0] POS_VAL_1   = 4'd7;
  localparam logic [3:0] POS_VAL_2   = 4'd8;
  localparam logic [3:0] POS_VAL_3   = 4'd9;
  localparam logic [3:0] POS_CRC_LO  = 4'd10;
  localparam logic [3:0] POS_CRC_HI  = 4'd11;

  // response byte that carries the echoed request sequence
  localparam logic [3:0] POS_ECHO_SEQ = 4'd4;
  // response byte that carries the free slot count
  localparam logic [3:0] POS_FREE     = 4'd5;
  // response byte that carries the buffer state
  localparam logic [3:0] POS_BUF_STATE = 4'd7;

  // crc
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] BUF_FULL_MARK = 8'd4;

  // register indexes
  localparam logic [1:0] REG_MAGIC       = 2'd0;
  localparam logic [1:0] REG_VERSION     = 2'd1;
  localparam logic [1:0] REG_STATUS_TYPE = 2'd2;
  localparam logic [1:0] REG_ACK_TYPE    = 2'd3;

  // command codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RX_BYTE = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_UNAVAIL  = 2'd1;
  localparam logic [1:0] VERDICT_BUF_FULL = 2'd2;
  localparam logic [1:0] VERDICT_REJECTED = 2'd3;

  typedef enum logic {
    JOB_FRAMES  = 1'b0,
    JOB_VERDICT = 1'b1
  } job_kind_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  msg_type;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [31:0] value;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last_of_run;
    logic       verdict_valid;
    logic [1:0] verdict;
    logic [7:0] free_slots;
  } out_item_t;

  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
    logic [7:0] status_type;
    logic [7:0] ack_type;
  } cfg_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  msg_type;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [31:0] value;
    logic [7:0]  seq;
    logic [7:0]  free_slots;
    logic [1:0]  verdict;
  } job_t;

  // msb-first crc update over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/crcfrl_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrl_queue
// Short job queue between the front and the back, one push and one pop
// per cycle.
// ---------------------------------------------------------------------------
module crcfrl_queue import crcfrl_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/crcfrl_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrl_front
// Takes input beats, numbers requests, collects and checks response frames
// and queues one job per request or completed response.
// ---------------------------------------------------------------------------
module crcfrl_front import crcfrl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire cfg_t     cfg,
  input  wire logic     queue_full,
  output logic          push,
  output job_t          push_job
);

  logic [7:0]  seq_cnt_r, seq_cnt_nxt;
  logic [7:0]  req_seq_r, req_seq_nxt;
  logic [3:0]  rsp_cnt_r, rsp_cnt_nxt;
  logic [15:0] rsp_crc_r, rsp_crc_nxt;
  logic [7:0]  free_slots_r, free_slots_nxt;
  logic [7:0]  rsp_bytes_r [FRAME_LEN];

  logic        accept;
  logic        is_req;
  logic        rsp_last;
  logic [7:0]  seq_first;
  logic [15:0] got_crc;
  logic        frame_good;
  logic [1:0]  verdict;

  assign in_stall  = queue_full;
  assign accept    = in_valid & ~queue_full;
  assign is_req    = (in_data.command == CMD_REQUEST);
  assign rsp_last  = (rsp_cnt_r == 4'(FRAME_LEN - 1));
  assign seq_first = seq_cnt_r + 8'd1;
  assign push      = accept & (is_req | rsp_last);

  // response check, the incoming byte is the crc high byte
  assign got_crc    = {in_data.rx_byte, rsp_bytes_r[POS_CRC_LO]};
  assign frame_good = (rsp_bytes_r[POS_MAGIC] == cfg.magic) &&
                      (rsp_bytes_r[POS_VERSION] == cfg.version) &&
                      (rsp_crc_r == got_crc) &&
                      (rsp_bytes_r[POS_ECHO_SEQ] == req_seq_r);

  always_comb begin
    if (!frame_good) begin
      verdict = VERDICT_UNAVAIL;
    end else if (rsp_bytes_r[POS_TYPE] == cfg.ack_type) begin
      verdict = VERDICT_OK;
    end else if (rsp_bytes_r[POS_BUF_STATE] == BUF_FULL_MARK) begin
      verdict = VERDICT_BUF_FULL;
    end else begin
      verdict = VERDICT_REJECTED;
    end
  end

  // state update
  always_comb begin
    seq_cnt_nxt    = seq_cnt_r;
    req_seq_nxt    = req_seq_r;
    rsp_cnt_nxt    = rsp_cnt_r;
    rsp_crc_nxt    = rsp_crc_r;
    free_slots_nxt = free_slots_r;
    if (accept) begin
      if (is_req) begin
        seq_cnt_nxt = seq_cnt_r + 8'd2;
        req_seq_nxt = seq_first;
        rsp_cnt_nxt = '0;
        rsp_crc_nxt = CRC_INIT;
      end else if (rsp_last) begin
        rsp_cnt_nxt = '0;
        rsp_crc_nxt = CRC_INIT;
        if (frame_good) begin
          free_slots_nxt = rsp_bytes_r[POS_FREE];
        end
      end else begin
        rsp_cnt_nxt = rsp_cnt_r + 4'd1;
        if (rsp_cnt_r < POS_CRC_LO) begin
          rsp_crc_nxt = crc16_byte(rsp_crc_r, in_data.rx_byte);
        end
      end
    end
  end

  // job to queue
  always_comb begin
    push_job             = '0;
    push_job.msg_type    = in_data.msg_type;
    push_job.first_byte  = in_data.first_byte;
    push_job.second_byte = in_data.second_byte;
    push_job.value       = in_data.value;
    push_job.seq         = seq_first;
    if (is_req) begin
      push_job.kind       = JOB_FRAMES;
      push_job.free_slots = free_slots_r;
      push_job.verdict    = VERDICT_OK;
    end else begin
      push_job.kind       = JOB_VERDICT;
      push_job.free_slots = free_slots_nxt;
      push_job.verdict    = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_cnt_r    <= '0;
      req_seq_r    <= '0;
      rsp_cnt_r    <= '0;
      rsp_crc_r    <= CRC_INIT;
      free_slots_r <= '0;
    end else begin
      seq_cnt_r    <= seq_cnt_nxt;
      req_seq_r    <= req_seq_nxt;
      rsp_cnt_r    <= rsp_cnt_nxt;
      rsp_crc_r    <= rsp_crc_nxt;
      free_slots_r <= free_slots_nxt;
    end
  end

  // response byte store
  always_ff @(posedge clk) begin
    if (accept && !is_req) begin
      rsp_bytes_r[rsp_cnt_r] <= in_data.rx_byte;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/crcfrl_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrl_back
// Turns queued jobs into result beats: 24 frame bytes with running crc for a
// request, one verdict beat for a completed response.
// ---------------------------------------------------------------------------
module crcfrl_back import crcfrl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      head_valid,
  input  wire job_t      head_job,
  input  wire cfg_t      cfg,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic [4:0]  byte_idx_r, byte_idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        load;
  logic        step;
  logic        is_frames;
  logic        in_poll;
  logic        frames_last;
  logic [3:0]  frame_pos;
  logic [7:0]  frame_byte;
  out_item_t   beat;

  assign load        = ~out_valid_r | ~out_stall;
  assign step        = load & head_valid;
  assign is_frames   = (head_job.kind == JOB_FRAMES);
  assign in_poll     = (byte_idx_r >= 5'(FRAME_LEN));
  assign frame_pos   = in_poll ? 4'(byte_idx_r - 5'(FRAME_LEN)) : byte_idx_r[3:0];
  assign frames_last = (byte_idx_r == 5'(2 * FRAME_LEN - 1));
  assign pop         = step & (~is_frames | frames_last);

  // frame byte select, poll frame carries zero arguments
  always_comb begin
    case (frame_pos)
      POS_MAGIC:   frame_byte = cfg.magic;
      POS_VERSION: frame_byte = cfg.version;
      POS_TYPE:    frame_byte = in_poll ? cfg.status_type : head_job.msg_type;
      POS_SEQ:     frame_byte = in_poll ? head_job.seq + 8'd1 : head_job.seq;
      POS_ARG_A:   frame_byte = in_poll ? 8'd0 : head_job.first_byte;
      POS_ARG_B:   frame_byte = in_poll ? 8'd0 : head_job.second_byte;
      POS_VAL_0:   frame_byte = in_poll ? 8'd0 : head_job.value[7:0];
      POS_VAL_1:   frame_byte = in_poll ? 8'd0 : head_job.value[15:8];
      POS_VAL_2:   frame_byte = in_poll ? 8'd0 : head_job.value[23:16];
      POS_VAL_3:   frame_byte = in_poll ? 8'd0 : head_job.value[31:24];
      POS_CRC_LO:  frame_byte = crc_r[7:0];
      POS_CRC_HI:  frame_byte = crc_r[15:8];
      default:     frame_byte = 8'd0;
    endcase
  end

  // result beat
  always_comb begin
    beat            = '0;
    beat.free_slots = head_job.free_slots;
    if (is_frames) begin
      beat.tx_byte     = frame_byte;
      beat.tx_valid    = 1'b1;
      beat.last_of_run = frames_last;
    end else begin
      beat.last_of_run   = 1'b1;
      beat.verdict_valid = 1'b1;
      beat.verdict       = head_job.verdict;
    end
  end

  // byte counter and running crc
  always_comb begin
    byte_idx_nxt = byte_idx_r;
    crc_nxt      = crc_r;
    if (step && is_frames) begin
      byte_idx_nxt = frames_last ? 5'd0 : byte_idx_r + 5'd1;
      if (frame_pos < POS_CRC_LO) begin
        crc_nxt = crc16_byte(crc_r, frame_byte);
      end else if (frame_pos == POS_CRC_HI) begin
        crc_nxt = CRC_INIT;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = load ? head_valid : out_valid_r;
    out_data_nxt  = step ? beat : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r  <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      byte_idx_r  <= byte_idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/crc16_framed_request_link_top.sv -----
`default_nettype none
// First result beat: the job is written into a queue slot, then the back end registers the beat onto out_data.
// Throughput: a request gives 24 beats at one per cycle while out_stall is low, set by the back end's byte
// counter; a completed response gives one beat.
// Response bytes that do not complete a frame give no beat.
// Reset: synchronous, active low; clears counters, queue, output valid and the four
// registers; the response byte store is not cleared.
// ---------------------------------------------------------------------------
// crc16_framed_request_link_top
// Framed request/poll link with crc-16 framing, response checking and an
// apb-style register port.
// ---------------------------------------------------------------------------
module crc16_framed_request_link_top import crcfrl_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       q_full;
  logic       q_push;
  job_t       q_push_job;
  logic       q_pop;
  logic       q_head_valid;
  job_t       q_head_job;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_MAGIC:       cfg_nxt.magic       = pwdata[7:0];
        REG_VERSION:     cfg_nxt.version     = pwdata[7:0];
        REG_STATUS_TYPE: cfg_nxt.status_type = pwdata[7:0];
        REG_ACK_TYPE:    cfg_nxt.ack_type    = pwdata[7:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAGIC:       prdata = {24'd0, cfg_r.magic};
      REG_VERSION:     prdata = {24'd0, cfg_r.version};
      REG_STATUS_TYPE: prdata = {24'd0, cfg_r.status_type};
      REG_ACK_TYPE:    prdata = {24'd0, cfg_r.ack_type};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end
  crcfrl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .queue_full (q_full),
    .push       (q_push),
    .push_job   (q_push_job)
  );

  // job queue
  crcfrl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // back end
  crcfrl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .cfg        (cfg_r),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // a full queue means the back end has a beat on offer
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("queue full while no result beat is offered");

  // frame bytes stream without gaps until the last one
  a_frame_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.tx_valid && !out_data.last_of_run)
      |=> out_valid)
    else $error("gap inside a frame run");

  // reset leaves output empty and input open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output or stall active after reset");

endmodule
`default_nettype wire

// ----- verif/crc16_framed_request_link_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// crc16_framed_request_link_checker
// Watches the request, result and register ports of the framed request link,
// keeps its own copy of the link state and registers, works out the frame
// and verdict beats that each accepted input beat must give, and compares
// every accepted result beat with the oldest one still waiting.
// ---------------------------------------------------------------------------

// frame helpers shared with the stimulus side
package link_frame_pkg;
  import crcfrl_pkg::*;

  typedef logic [7:0] frame_bytes_t [0:11];

  // crc-16/ccitt-false over the ten header and payload bytes, msb first
  function automatic logic [15:0] frame_crc16(input frame_bytes_t f);
    logic [15:0] acc;
    acc = CRC_INIT;
    for (int i = 0; i < 10; i++) begin
      acc = acc ^ {f[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        if (acc[15]) begin
          acc = {acc[14:0], 1'b0} ^ CRC_POLY;
        end else begin
          acc = {acc[14:0], 1'b0};
        end
      end
    end
    return acc;
  endfunction

endpackage

module crc16_framed_request_link_checker
  import crcfrl_pkg::*;
  import link_frame_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire in_item_t          in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire out_item_t         out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  input  wire logic [31:0]       prdata,
  input  wire logic              pready,
  output int unsigned            pending_beats,
  output int unsigned            fail_count,
  output int unsigned            beats_checked,
  output int unsigned            verdicts_checked
);

  // register copy
  logic [7:0] cfg_magic, cfg_version, cfg_status, cfg_ack;

  // link state copy
  logic [7:0]   seq_ctr;
  logic [7:0]   req_seq;
  logic [3:0]   rx_count;
  frame_bytes_t rx_frame;
  logic [7:0]   free_slot_q;

  out_item_t    expected_beats[$];
  out_item_t    head;
  int unsigned  err_cnt, n_checked, n_verdicts;

  function automatic logic [7:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_MAGIC:       return cfg_magic;
      REG_VERSION:     return cfg_version;
      REG_STATUS_TYPE: return cfg_status;
      default:         return cfg_ack;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // one 12-byte frame as tx beats, crc low byte first
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] seq,
                             input logic [7:0] arg_a, input logic [7:0] arg_b,
                             input logic [31:0] val, input bit closes_run);
    frame_bytes_t f;
    logic [15:0]  crc;
    out_item_t    beat;
    f[POS_MAGIC]   = cfg_magic;
    f[POS_VERSION] = cfg_version;
    f[POS_TYPE]    = ftype;
    f[POS_SEQ]     = seq;
    f[POS_ARG_A]   = arg_a;
    f[POS_ARG_B]   = arg_b;
    f[POS_VAL_0]   = val[7:0];
    f[POS_VAL_1]   = val[15:8];
    f[POS_VAL_2]   = val[23:16];
    f[POS_VAL_3]   = val[31:24];
    f[POS_CRC_LO]  = 8'h00;
    f[POS_CRC_HI]  = 8'h00;
    crc = frame_crc16(f);
    f[POS_CRC_LO]  = crc[7:0];
    f[POS_CRC_HI]  = crc[15:8];
    for (int i = 0; i < FRAME_LEN; i++) begin
      beat               = '0;
      beat.tx_byte       = f[i];
      beat.tx_valid      = 1'b1;
      beat.last_of_run   = closes_run && (i == FRAME_LEN - 1);
      beat.verdict_valid = 1'b0;
      beat.verdict       = VERDICT_OK;
      beat.free_slots    = free_slot_q;
      expected_beats.push_back(beat);
    end
  endtask

  // expected result beats of one accepted input beat
  task automatic predict_beat(input in_item_t it);
    logic [15:0] crc_got;
    logic [1:0]  v;
    out_item_t   beat;
    if (it.command == CMD_REQUEST) begin
      // request frame takes the first new sequence number, poll the second
      seq_ctr = seq_ctr + 8'd1;
      req_seq = seq_ctr;
      queue_frame(it.msg_type, req_seq, it.first_byte, it.second_byte, it.value, 1'b0);
      seq_ctr = seq_ctr + 8'd1;
      queue_frame(cfg_status, seq_ctr, 8'h00, 8'h00, 32'h0, 1'b1);
      rx_count = '0;
    end else begin
      rx_frame[rx_count] = it.rx_byte;
      rx_count = rx_count + 4'd1;
      if (rx_count == FRAME_LEN) begin
        rx_count = '0;
        crc_got = {rx_frame[POS_CRC_HI], rx_frame[POS_CRC_LO]};
        if (rx_frame[POS_MAGIC] != cfg_magic || rx_frame[POS_VERSION] != cfg_version ||
            frame_crc16(rx_frame) != crc_got || rx_frame[POS_ECHO_SEQ] != req_seq) begin
          v = VERDICT_UNAVAIL;
        end else begin
          free_slot_q = rx_frame[POS_FREE];
          if (rx_frame[POS_TYPE] == cfg_ack) begin
            v = VERDICT_OK;
          end else if (rx_frame[POS_BUF_STATE] == BUF_FULL_MARK) begin
            v = VERDICT_BUF_FULL;
          end else begin
            v = VERDICT_REJECTED;
          end
        end
        beat               = '0;
        beat.last_of_run   = 1'b1;
        beat.verdict_valid = 1'b1;
        beat.verdict       = v;
        beat.free_slots    = free_slot_q;
        expected_beats.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_magic   = '0;
      cfg_version = '0;
      cfg_status  = '0;
      cfg_ack     = '0;
      seq_ctr     = '0;
      req_seq     = '0;
      rx_count    = '0;
      free_slot_q = '0;
      expected_beats.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_MAGIC:       cfg_magic   = pwdata[7:0];
            REG_VERSION:     cfg_version = pwdata[7:0];
            REG_STATUS_TYPE: cfg_status  = pwdata[7:0];
            REG_ACK_TYPE:    cfg_ack     = pwdata[7:0];
            default: ;
          endcase
        end else begin
          compare_field("prdata", {24'h0, reg_value(paddr[ADDR_W-1:2])}, prdata);
        end
      end

      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("result beat %0h arrived with nothing expected", out_data);
          err_cnt++;
        end else begin
          head = expected_beats.pop_front();
          compare_field("tx_byte", 32'(head.tx_byte), 32'(out_data.tx_byte));
          compare_field("tx_valid", 32'(head.tx_valid), 32'(out_data.tx_valid));
          compare_field("last_of_run", 32'(head.last_of_run), 32'(out_data.last_of_run));
          compare_field("verdict_valid", 32'(head.verdict_valid),
                        32'(out_data.verdict_valid));
          compare_field("verdict", 32'(head.verdict), 32'(out_data.verdict));
          compare_field("free_slots", 32'(head.free_slots), 32'(out_data.free_slots));
          n_checked++;
          if (head.verdict_valid) n_verdicts++;
        end
      end

      // input beat
      if (in_valid && !in_stall) predict_beat(in_data);
    end
    pending_beats    <= expected_beats.size();
    fail_count       <= err_cnt;
    beats_checked    <= n_checked;
    verdicts_checked <= n_verdicts;
  end

endmodule

// ----- verif/crc16_framed_request_link_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// crc16_framed_request_link_top_tb
// Drives request and response byte beats into the framed request link under
// several register settings and idling mixes, including a long output
// hold-off and a sequence number wrap; the checker beside the block judges
// every result beat and this module gives the verdict.
// ---------------------------------------------------------------------------
module crc16_framed_request_link_top_tb;
  import crcfrl_pkg::*;
  import link_frame_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_LEN      = 400;

  typedef enum int {
    RESP_OK, RESP_BUF_FULL, RESP_REJECT, RESP_BAD_MAGIC,
    RESP_BAD_VERSION, RESP_BAD_CRC, RESP_BAD_SEQ
  } resp_kind_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_item_t          in_data   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic              in_stall;
  logic              out_valid;
  out_item_t         out_data;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned pending_beats, fail_count, beats_checked, verdicts_checked;

  // stimulus bookkeeping
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  bit          hold_on       = 1'b0;
  int          hold_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned n_req         = 0;
  int unsigned n_rx          = 0;
  logic [7:0]  next_seq      = '0;
  logic [7:0]  echo_seq      = '0;
  logic [7:0]  cur_magic = '0, cur_version = '0, cur_ack = '0;

  crc16_framed_request_link_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  crc16_framed_request_link_checker i_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .pending_beats    (pending_beats),
    .fail_count       (fail_count),
    .beats_checked    (beats_checked),
    .verdicts_checked (verdicts_checked)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_on && hold_count < HOLD_LEN) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic resp_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return RESP_OK;
    if (r < 50) return RESP_BUF_FULL;
    if (r < 65) return RESP_REJECT;
    if (r < 72) return RESP_BAD_MAGIC;
    if (r < 79) return RESP_BAD_VERSION;
    if (r < 90) return RESP_BAD_CRC;
    return RESP_BAD_SEQ;
  endfunction

  // one input beat, with random sender gaps ahead of it
  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_request(input logic [7:0] msg, input logic [7:0] arg_a,
                              input logic [7:0] arg_b, input logic [31:0] val);
    in_item_t it;
    it             = random_item();
    it.command     = CMD_REQUEST;
    it.msg_type    = msg;
    it.first_byte  = arg_a;
    it.second_byte = arg_b;
    it.value       = val;
    next_seq       = next_seq + 8'd1;
    echo_seq       = next_seq;
    next_seq       = next_seq + 8'd1;
    send_beat(it);
    n_req++;
  endtask

  task automatic send_rx_byte(input logic [7:0] b);
    in_item_t it;
    it         = random_item();
    it.command = CMD_RX_BYTE;
    it.rx_byte = b;
    send_beat(it);
    n_rx++;
  endtask

  // twelve response bytes aimed at one verdict, or broken in one place
  task automatic send_response(input resp_kind_t kind);
    frame_bytes_t f;
    logic [15:0]  crc;
    logic [7:0]   nz;
    nz             = 8'($urandom_range(255, 1));
    f[POS_MAGIC]   = cur_magic;
    f[POS_VERSION] = cur_version;
    case (kind)
      RESP_OK:                    f[POS_TYPE] = cur_ack;
      RESP_BUF_FULL, RESP_REJECT: f[POS_TYPE] = cur_ack ^ nz;
      default:                    f[POS_TYPE] = pick_byte();
    endcase
    f[POS_SEQ]       = pick_byte();
    f[POS_ECHO_SEQ]  = echo_seq;
    f[POS_FREE]      = pick_byte();
    f[POS_VAL_0]     = pick_byte();
    f[POS_BUF_STATE] = (kind == RESP_BUF_FULL) ? BUF_FULL_MARK : pick_byte();
    if (kind == RESP_REJECT && f[POS_BUF_STATE] == BUF_FULL_MARK) begin
      f[POS_BUF_STATE] = f[POS_BUF_STATE] ^ 8'h01;
    end
    f[POS_VAL_2]  = pick_byte();
    f[POS_VAL_3]  = pick_byte();
    f[POS_CRC_LO] = 8'h00;
    f[POS_CRC_HI] = 8'h00;
    if (kind == RESP_BAD_MAGIC)   f[POS_MAGIC]    = f[POS_MAGIC] ^ nz;
    if (kind == RESP_BAD_VERSION) f[POS_VERSION]  = f[POS_VERSION] ^ nz;
    if (kind == RESP_BAD_SEQ)     f[POS_ECHO_SEQ] = f[POS_ECHO_SEQ] ^ nz;
    crc = frame_crc16(f);
    f[POS_CRC_LO] = crc[7:0];
    f[POS_CRC_HI] = crc[15:8];
    if (kind == RESP_BAD_CRC) begin
      if ($urandom_range(1)) f[POS_CRC_LO] = f[POS_CRC_LO] ^ nz;
      else f[POS_CRC_HI] = f[POS_CRC_HI] ^ nz;
    end
    for (int i = 0; i < FRAME_LEN; i++) send_rx_byte(f[i]);
  endtask

  // mostly request plus matching response, some bare beats and stray bytes
  task automatic run_traffic(input int unsigned target);
    int unsigned start;
    int          r;
    start = items_sent;
    while (items_sent - start < target) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_request(pick_byte(), pick_byte(), pick_byte(), pick_word());
        send_response(pick_kind());
      end else if (r < 70) begin
        send_response(pick_kind());
      end else if (r < 85) begin
        send_request(pick_byte(), pick_byte(), pick_byte(), pick_word());
      end else begin
        repeat ($urandom_range(14, 1)) send_rx_byte(8'($urandom));
      end
    end
  endtask

  // wait out every expected beat and any byte still in flight
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write all four registers, then read them back
  task automatic configure(input logic [7:0] magic, input logic [7:0] version,
                           input logic [7:0] status, input logic [7:0] ack);
    apb_access(1'b1, REG_MAGIC, magic);
    apb_access(1'b1, REG_VERSION, version);
    apb_access(1'b1, REG_STATUS_TYPE, status);
    apb_access(1'b1, REG_ACK_TYPE, ack);
    cur_magic   = magic;
    cur_version = version;
    cur_ack     = ack;
    apb_access(1'b0, REG_MAGIC, 8'h00);
    apb_access(1'b0, REG_VERSION, 8'h00);
    apb_access(1'b0, REG_STATUS_TYPE, 8'h00);
    apb_access(1'b0, REG_ACK_TYPE, 8'h00);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: response before any request, field extremes, response cut short
    send_response(RESP_OK);
    send_request(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_rx_byte(8'h00);
    send_rx_byte(8'hFF);
    send_request(8'h00, 8'h00, 8'h00, 32'h0000_0000);
    drain();

    // all registers at the top end, no idling
    configure(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_traffic(15);
    drain();

    // random registers, sender gaps
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 55;
    run_traffic(15);
    drain();

    // mixed extremes, receiver stalls
    configure(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_idle_pct = 0;
    stall_pct     = 55;
    run_traffic(15);
    drain();

    // random registers, both sides idling
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 37;
    stall_pct     = 37;
    run_traffic(15);
    drain();

    // long hold-off while requests keep coming; carries the sequence past a wrap
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_on       = 1'b1;
    repeat (128) send_request(pick_byte(), pick_byte(), pick_byte(), pick_word());
    send_response(RESP_OK);
    send_response(pick_kind());
    drain();

    $display("covered %0d request beats and %0d response bytes over six register settings",
             n_req, n_rx);
    $display("compared %0d result beats, %0d verdicts, with a long hold-off and sequence wrap",
             beats_checked, verdicts_checked);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
